// ===== sv/tmma_pkg.sv =====
// ----------------------------------------------------------------------------
// tmma_pkg
// Shared types, codes and constants of the tiled matrix multiply-accumulate
// engine.
// ----------------------------------------------------------------------------
package tmma_pkg;

  // Default edge length of the square tiles
  localparam int unsigned TILE_DEFAULT = 8;

  // Field widths of the item and result transactions
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned ELEM_W  = 16;
  localparam int unsigned PROD_W  = 32;
  localparam int unsigned ACC_W   = 40;
  localparam int unsigned SIZE_W  = 4;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_TILE_IN_USE   = 1'b0;   // word index of the register
  localparam logic [SIZE_W-1:0] TILE_IN_USE_RESET = 4'd8;

  // Saturation limits of the accumulator
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_RUN    = 2'd2
  } kind_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_ACC_RD,
    S_MAC,
    S_DRAIN0,
    S_DRAIN1,
    S_WRITE,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_a;       // store element into tile A
    logic wr_b;       // store element into tile B
    logic clear;      // invalidate the first count accumulator entries
    logic acc_rd;     // read accumulator entry at acc_addr
    logic acc_wr;     // write running sum to accumulator entry at acc_addr
    logic mac_issue;  // read one A/B pair into the MAC pipeline
    logic acc_load;   // seed running sum from the accumulator read data
    logic out_load;   // load output register from accumulator read data
    logic out_last;   // last element of the emitted tile
  } tmma_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;   // output register is empty or drains this cycle
  } tmma_status_t;

endpackage

// ===== sv/tmma_if.sv =====
// ----------------------------------------------------------------------------
// tmma_item_if / tmma_result_if
// Valid/ready channels carrying input items and emitted accumulator elements.
// ----------------------------------------------------------------------------
interface tmma_item_if;
  logic                                  valid;
  logic                                  ready;
  logic [tmma_pkg::KIND_W-1:0]           kind;
  logic [tmma_pkg::INDEX_W-1:0]          element_index;
  logic signed [tmma_pkg::ELEM_W-1:0]    element_value;
  logic                                  clear_first;
  logic                                  emit_after;

  modport source (
    output valid, kind, element_index, element_value, clear_first, emit_after,
    input  ready
  );
  modport sink (
    input  valid, kind, element_index, element_value, clear_first, emit_after,
    output ready
  );
endinterface

interface tmma_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tmma_pkg::ACC_W-1:0]     result_value;
  logic [tmma_pkg::INDEX_W-1:0]          result_index;
  logic                                  result_last;

  modport source (
    output valid, result_value, result_index, result_last,
    input  ready
  );
  modport sink (
    input  valid, result_value, result_index, result_last,
    output ready
  );
endinterface

// ===== sv/tmma_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmma_ctrl
// Sequencer: accepts items, walks rows, columns and the inner k loop of a
// run, and steps through the accumulator tile when emitting.
// ----------------------------------------------------------------------------
module tmma_ctrl #(
  parameter  int unsigned TILE = tmma_pkg::TILE_DEFAULT,
  localparam int unsigned AW   = (TILE > 1) ? $clog2(TILE * TILE) : 1,
  localparam int unsigned CW   = $clog2(TILE * TILE + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  logic [tmma_pkg::KIND_W-1:0]     item_kind,
  input  logic                            item_clear_first,
  input  logic                            item_emit_after,
  output logic                            item_ready,
  input  logic [tmma_pkg::SIZE_W-1:0]     tile_in_use,
  output tmma_pkg::tmma_cmd_t             cmd,
  input  tmma_pkg::tmma_status_t          status,
  output logic [AW-1:0]                   a_addr,
  output logic [AW-1:0]                   b_addr,
  output logic [AW-1:0]                   acc_addr,
  output logic [CW-1:0]                   count
);
  import tmma_pkg::*;

  localparam int unsigned CTW = (TILE > 1) ? $clog2(TILE) : 1;
  localparam int unsigned NW  = $clog2(TILE + 1);

  state_t          state;
  state_t          state_next;
  logic [CTW-1:0]  i;
  logic [CTW-1:0]  j;
  logic [CTW-1:0]  k;
  logic [AW-1:0]   row_base;   // i * n
  logic [AW-1:0]   kb;         // k * n
  logic [AW-1:0]   e;          // emit position
  logic [NW-1:0]   n_q;
  logic [CW-1:0]   count_q;
  logic            clear_q;
  logic            emit_q;

  logic [NW-1:0]   n_eff;
  logic [CW-1:0]   count_eff;
  logic [AW-1:0]   c_addr;
  logic            k_last;
  logic            j_last;
  logic            i_last;
  logic            e_last;

  // Edge length clamped to 1..TILE
  always_comb begin
    if (tile_in_use == '0) begin
      n_eff = NW'(1);
    end else if (tile_in_use > SIZE_W'(TILE)) begin
      n_eff = NW'(TILE);
    end else begin
      n_eff = NW'(tile_in_use);
    end
    count_eff = CW'(CW'(n_eff) * CW'(n_eff));
  end

  // Loop end flags
  assign k_last = (NW'(k) + NW'(1)) == n_q;
  assign j_last = (NW'(j) + NW'(1)) == n_q;
  assign i_last = (NW'(i) + NW'(1)) == n_q;
  assign e_last = (CW'(e) + CW'(1)) == count_q;

  // Memory addresses
  assign a_addr   = row_base + AW'(k);
  assign b_addr   = kb + AW'(j);
  assign c_addr   = row_base + AW'(j);
  assign acc_addr = (state == S_EMIT_RD || state == S_EMIT_LD) ? e : c_addr;
  assign count    = count_q;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Loop counters and run settings
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (item_valid && item_kind == KIND_RUN) begin
          n_q     <= n_eff;
          count_q <= count_eff;
          clear_q <= item_clear_first;
          emit_q  <= item_emit_after;
        end
      end
      S_START: begin
        i        <= '0;
        j        <= '0;
        row_base <= '0;
        e        <= '0;
      end
      S_ACC_RD: begin
        k  <= '0;
        kb <= '0;
      end
      S_MAC: begin
        k  <= k + CTW'(1);
        kb <= kb + AW'(n_q);
      end
      S_WRITE: begin
        if (j_last) begin
          j <= '0;
          if (!i_last) begin
            i        <= i + CTW'(1);
            row_base <= row_base + AW'(n_q);
          end
        end else begin
          j <= j + CTW'(1);
        end
      end
      S_EMIT_LD: begin
        if (status.out_free && !e_last) begin
          e <= e + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          case (item_kind)
            KIND_LOAD_A: cmd.wr_a = 1'b1;
            KIND_LOAD_B: cmd.wr_b = 1'b1;
            KIND_RUN:    state_next = S_START;
            default: begin
            end
          endcase
        end
      end
      S_START: begin
        cmd.clear  = clear_q;
        state_next = S_ACC_RD;
      end
      S_ACC_RD: begin
        cmd.acc_rd = 1'b1;
        state_next = S_MAC;
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        cmd.acc_load  = (k == '0);
        if (k_last) begin
          state_next = S_DRAIN0;
        end
      end
      S_DRAIN0: state_next = S_DRAIN1;
      S_DRAIN1: state_next = S_WRITE;
      S_WRITE: begin
        cmd.acc_wr = 1'b1;
        if (j_last && i_last) begin
          state_next = emit_q ? S_EMIT_RD : S_IDLE;
        end else begin
          state_next = S_ACC_RD;
        end
      end
      S_EMIT_RD: begin
        cmd.acc_rd = 1'b1;
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = e_last;
          state_next   = e_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // The inner loop never runs past the edge length
  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC) |-> (NW'(k) < n_q))
    else $error("k counter beyond edge length");

endmodule

// ===== sv/tmma_dp.sv =====
// ----------------------------------------------------------------------------
// tmma_dp
// Datapath: tile A/B memories, accumulator memory with valid bits, a
// registered multiply / saturating add pipeline and the output register.
// ----------------------------------------------------------------------------
module tmma_dp #(
  parameter  int unsigned TILE = tmma_pkg::TILE_DEFAULT,
  localparam int unsigned AW   = (TILE > 1) ? $clog2(TILE * TILE) : 1,
  localparam int unsigned CW   = $clog2(TILE * TILE + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tmma_pkg::tmma_cmd_t               cmd,
  output tmma_pkg::tmma_status_t            status,
  input  logic [AW-1:0]                     a_addr,
  input  logic [AW-1:0]                     b_addr,
  input  logic [AW-1:0]                     acc_addr,
  input  logic [CW-1:0]                     count,
  input  logic [tmma_pkg::INDEX_W-1:0]      element_index,
  input  logic signed [tmma_pkg::ELEM_W-1:0] element_value,
  tmma_result_if.source                     results
);
  import tmma_pkg::*;

  localparam int unsigned DEPTH = TILE * TILE;

  logic signed [ELEM_W-1:0] tile_a   [DEPTH];
  logic signed [ELEM_W-1:0] tile_b   [DEPTH];
  logic signed [ACC_W-1:0]  acc_mem  [DEPTH];
  logic [DEPTH-1:0]         acc_valid;

  logic                     idx_ok;
  logic signed [ELEM_W-1:0] a_q;
  logic signed [ELEM_W-1:0] b_q;
  logic                     v1;
  logic signed [PROD_W-1:0] prod;
  logic                     v2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W:0]    sum;
  logic signed [ACC_W-1:0]  sum_sat;
  logic signed [ACC_W-1:0]  acc_rd_q;
  logic                     acc_vld_q;
  logic signed [ACC_W-1:0]  acc_rd_val;

  logic                     out_valid;
  logic signed [ACC_W-1:0]  out_value;
  logic [INDEX_W-1:0]       out_index;
  logic                     out_last;

  // Loads beyond the tile storage are dropped
  assign idx_ok = {1'b0, element_index} < (INDEX_W + 1)'(DEPTH);

  // Tile A/B memories
  always_ff @(posedge clk) begin
    if (cmd.wr_a && idx_ok) begin
      tile_a[element_index[AW-1:0]] <= element_value;
    end
    if (cmd.wr_b && idx_ok) begin
      tile_b[element_index[AW-1:0]] <= element_value;
    end
    if (cmd.mac_issue) begin
      a_q <= tile_a[a_addr];
      b_q <= tile_b[b_addr];
    end
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    if (v1) begin
      prod <= PROD_W'(a_q * b_q);
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.mac_issue;
      v2 <= v1;
    end
  end

  // Saturating accumulate
  assign sum = {acc[ACC_W-1], acc} + (ACC_W + 1)'(prod);
  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sum_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum[ACC_W-1:0];
    end
  end

  assign acc_rd_val = acc_vld_q ? acc_rd_q : '0;

  always_ff @(posedge clk) begin
    if (cmd.acc_load) begin
      acc <= acc_rd_val;
    end else if (v2) begin
      acc <= sum_sat;
    end
  end

  // Accumulator memory
  always_ff @(posedge clk) begin
    if (cmd.acc_wr) begin
      acc_mem[acc_addr] <= acc;
    end
    if (cmd.acc_rd) begin
      acc_rd_q  <= acc_mem[acc_addr];
      acc_vld_q <= acc_valid[acc_addr];
    end
  end

  // Valid bits: an invalid entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= '0;
    end else begin
      if (cmd.clear) begin
        for (int unsigned idx = 0; idx < DEPTH; idx++) begin
          if (CW'(idx) < count) begin
            acc_valid[idx] <= 1'b0;
          end
        end
      end
      if (cmd.acc_wr) begin
        acc_valid[acc_addr] <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value <= acc_rd_val;
      out_index <= INDEX_W'(acc_addr);
      out_last  <= cmd.out_last;
    end
  end

  assign results.valid        = out_valid;
  assign results.result_value = out_value;
  assign results.result_index = out_index;
  assign results.result_last  = out_last;
  assign status.out_free      = !out_valid || results.ready;

  // An emitted element never overwrites one still waiting
  a_out_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || results.ready))
    else $error("output register overrun");

  // Seeding the sum never collides with a product in flight
  a_seed_no_collision: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_load |-> !v2)
    else $error("accumulator seed collides with pipeline");

  // The sum is written back only after the pipeline has drained
  a_write_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_wr |-> !(v1 || v2 || cmd.mac_issue))
    else $error("accumulator written before pipeline drained");

endmodule

// ===== sv/tiled_matrix_multiply_accumulate_top.sv =====
// ----------------------------------------------------------------------------
// tiled_matrix_multiply_accumulate_top
// Square tile multiply-accumulate engine with Q8.8 inputs and a saturating
// 40-bit Q24.16 accumulator tile.
// ----------------------------------------------------------------------------
// Usage:
//   items   : valid/ready channel. A transaction loads one A or B element at a
//             row-major index, or starts a run (optional clear, A*B added into
//             the accumulator, optional emission of the tile).
//   results : valid/ready channel, one transaction per accumulator element in
//             row-major order, result_last set on the final one.
//   APB     : register tile_in_use at byte address 0 sets the edge length n.
// Sequence:
//   A load is written in S_IDLE. A run performs, per accumulator element, one
//   accumulator read, the MAC issues of the inner k loop, two pipeline stages
//   of drain and one write; emission reads each element through the single
//   accumulator memory port. Items are taken only while no run is in flight.
// Reset:
//   rst clears the controller, the pipeline valids and the accumulator valid
//   bits, so the accumulator reads as zero; tile_in_use returns to 8.
// Stall:
//   A stalled result holds in the output register; emission pauses until it
//   is taken. Once the last result is loaded new items are accepted again.
// ----------------------------------------------------------------------------
module tiled_matrix_multiply_accumulate_top #(
  parameter int unsigned TILE = tmma_pkg::TILE_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  tmma_item_if.sink                      items,
  tmma_result_if.source                  results,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tmma_pkg::PADDR_W-1:0]   paddr,
  input  logic [tmma_pkg::PDATA_W-1:0]   pwdata,
  output logic [tmma_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import tmma_pkg::*;

  localparam int unsigned AW = (TILE > 1) ? $clog2(TILE * TILE) : 1;
  localparam int unsigned CW = $clog2(TILE * TILE + 1);

  logic [SIZE_W-1:0] tile_in_use;
  tmma_cmd_t         cmd;
  tmma_status_t      status;
  logic [AW-1:0]     a_addr;
  logic [AW-1:0]     b_addr;
  logic [AW-1:0]     acc_addr;
  logic [CW-1:0]     count;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_in_use <= TILE_IN_USE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1] == REG_TILE_IN_USE) begin
      tile_in_use <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[PADDR_W-1] == REG_TILE_IN_USE) ?
                  PDATA_W'(tile_in_use) : '0;

  // Controller
  tmma_ctrl #(.TILE(TILE)) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (items.valid),
    .item_kind        (items.kind),
    .item_clear_first (items.clear_first),
    .item_emit_after  (items.emit_after),
    .item_ready       (items.ready),
    .tile_in_use      (tile_in_use),
    .cmd              (cmd),
    .status           (status),
    .a_addr           (a_addr),
    .b_addr           (b_addr),
    .acc_addr         (acc_addr),
    .count            (count)
  );

  // Datapath
  tmma_dp #(.TILE(TILE)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .a_addr        (a_addr),
    .b_addr        (b_addr),
    .acc_addr      (acc_addr),
    .count         (count),
    .element_index (items.element_index),
    .element_value (items.element_value),
    .results       (results)
  );

endmodule
